### hdl/cbas_pkg.sv
`default_nettype none
package cbas_pkg;

  localparam int unsigned CORES       = 4;
  localparam int unsigned BLOCK_WORDS = 4;   // power of two
  localparam int unsigned QUEUE_DEPTH = 8;   // power of two
  localparam int unsigned MEMORY_WAIT = 15;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned CID_W  = 2;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ORG_W  = 3;

  localparam int unsigned MEM_AW  = ADDR_W;  // one word per address
  localparam int unsigned CORE_W  = $clog2(CORES);
  localparam int unsigned HEAD_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WAIT_W  = $clog2(MEMORY_WAIT + 1);
  localparam int unsigned OFFS_W  = $clog2(BLOCK_WORDS);
  localparam int unsigned FIFO_AW = CORE_W + HEAD_W;
  localparam int unsigned FIFO_DEPTH = CORES * QUEUE_DEPTH;
  localparam int unsigned ENTRY_W = CMD_W + ADDR_W;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 96;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_TICK    = 3'd1,
    OP_OFFER   = 3'd2,
    OP_SHARED  = 3'd3,
    OP_MEM_WR  = 3'd4,
    OP_MEM_RD  = 3'd5
  } op_e;

  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RDX   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

  localparam logic [ORG_W-1:0] ORIGIN_MEMORY = 3'd4;

  typedef struct packed {
    logic load;
    logic read;
    logic commit;
  } ctl_t;

endpackage
`default_nettype wire

### hdl/coherent_bus_arbiter_sequencer_top.sv
// shared snooping bus for four cores: each input transfer is one operation (enqueue a
// request, advance the bus one tick, offer a snoop flush, raise shared, or access main
// memory) and yields exactly one result transfer with the bus lines after a tick, the
// enqueue acknowledge or the memory read word. from acceptance to a free input, with the
// result taken at once, an item goes through these steps: accept, the registered reads
// of the request queue and word memories, update state, present the result. request
// queues and main memory hold no reset value; reading a word never written returns
// anything
`default_nettype none
module coherent_bus_arbiter_sequencer_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // core_id[1:0], command[3:2], address[23:4], flush_word[55:24], write_word[87:56]
  input  wire logic [cbas_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // operation[2:0]
  input  wire logic [cbas_pkg::OP_W-1:0]           s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // bus_command[1:0], bus_origin[4:2], bus_address[24:5], bus_word[56:25],
  // bus_shared_line[57], accepted[58], read_word[90:59], zero[95:91]
  output logic [cbas_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,
  // trace_valid[0]
  output logic                                     m_axis_tuser_o
);

  cbas_pkg::ctl_t ctl;

  cbas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .ctl_o       (ctl)
  );

  cbas_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .op_i          (s_axis_tuser_i),
    .data_i        (s_axis_tdata_i),
    .trace_valid_o (m_axis_tuser_o),
    .data_o        (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

### hdl/cbas_ctrl.sv
`default_nettype none
module cbas_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output cbas_pkg::ctl_t      ctl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  state_e state_q;
  logic   rdy_q;
  logic   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
      vld_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_READ;
            rdy_q   <= 1'b0;
          end
        end
        ST_READ: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state_q <= ST_RESULT;
          vld_q   <= 1'b1;
        end
        ST_RESULT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
            vld_q   <= 1'b0;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = rdy_q;
  assign out_valid_o = vld_q;

  always_comb begin
    ctl_o.load   = in_valid_i && rdy_q;
    ctl_o.read   = (state_q == ST_READ);
    ctl_o.commit = (state_q == ST_UPDATE);
  end

endmodule
`default_nettype wire

### hdl/cbas_dpath.sv
`default_nettype none
module cbas_dpath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire cbas_pkg::ctl_t                      ctl_i,
  input  wire logic [cbas_pkg::OP_W-1:0]           op_i,
  input  wire logic [cbas_pkg::IN_TDATA_W-1:0]     data_i,
  output logic                                     trace_valid_o,
  output logic [cbas_pkg::OUT_TDATA_W-1:0]         data_o
);

  typedef enum logic [2:0] {
    K_ARB,
    K_WAIT,
    K_STEP,
    K_OFFER,
    K_MEMSTART
  } kind_e;

  localparam logic [cbas_pkg::ADDR_W-1:0] BASE_MASK =
    ~cbas_pkg::ADDR_W'(cbas_pkg::BLOCK_WORDS - 1);

  // item registers
  logic [cbas_pkg::OP_W-1:0]   op_q;
  logic [cbas_pkg::CID_W-1:0]  cid_q;
  logic [cbas_pkg::CMD_W-1:0]  cmdin_q;
  logic [cbas_pkg::ADDR_W-1:0] addr_q;
  logic [cbas_pkg::WORD_W-1:0] fw_q;
  logic [cbas_pkg::WORD_W-1:0] ww_q;

  // bus state
  logic [cbas_pkg::CNT_W-1:0]  cnt_q  [cbas_pkg::CORES];
  logic [cbas_pkg::CNT_W-1:0]  cnt_d  [cbas_pkg::CORES];
  logic [cbas_pkg::HEAD_W-1:0] head_q [cbas_pkg::CORES];
  logic [cbas_pkg::HEAD_W-1:0] head_d [cbas_pkg::CORES];
  logic [cbas_pkg::CORE_W-1:0] last_q, last_d;
  logic [cbas_pkg::CMD_W-1:0]  cur_cmd_q, cur_cmd_d;
  logic [cbas_pkg::ORG_W-1:0]  cur_org_q, cur_org_d;
  logic [cbas_pkg::ADDR_W-1:0] cur_addr_q, cur_addr_d;
  logic [cbas_pkg::WORD_W-1:0] cur_word_q, cur_word_d;
  logic                        shared_q, shared_d;
  logic [cbas_pkg::WAIT_W-1:0] wait_q, wait_d;
  logic [cbas_pkg::OFFS_W-1:0] offs_q, offs_d;
  logic                        offer_v_q, offer_v_d;
  logic [cbas_pkg::CORE_W-1:0] offer_core_q, offer_core_d;
  logic [cbas_pkg::ADDR_W-1:0] offer_addr_q, offer_addr_d;

  // memories
  logic [cbas_pkg::ENTRY_W-1:0] fifo_mem [cbas_pkg::FIFO_DEPTH];
  logic [cbas_pkg::WORD_W-1:0]  word_mem [2**cbas_pkg::MEM_AW];
  logic [cbas_pkg::ENTRY_W-1:0] fifo_rd_q;
  logic [cbas_pkg::WORD_W-1:0]  mem_rd_q;

  // result register
  logic                        res_trace_q, res_trace_d;
  logic [cbas_pkg::CMD_W-1:0]  res_cmd_q, res_cmd_d;
  logic [cbas_pkg::ORG_W-1:0]  res_org_q, res_org_d;
  logic [cbas_pkg::ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [cbas_pkg::WORD_W-1:0] res_word_q, res_word_d;
  logic                        res_shared_q, res_shared_d;
  logic                        res_acc_q, res_acc_d;
  logic [cbas_pkg::WORD_W-1:0] res_rdw_q, res_rdw_d;

  // decision signals
  logic                         bus_free;
  logic                         arb_found;
  logic [cbas_pkg::CORE_W-1:0]  arb_core;
  kind_e                        kind;
  logic [cbas_pkg::CORE_W-1:0]  rd_core;
  logic [cbas_pkg::FIFO_AW-1:0] fifo_raddr;
  logic [cbas_pkg::ADDR_W-1:0]  fl_addr;
  logic [cbas_pkg::MEM_AW-1:0]  mem_raddr;

  logic                         fifo_we;
  logic [cbas_pkg::FIFO_AW-1:0] fifo_waddr;
  logic [cbas_pkg::ENTRY_W-1:0] fifo_wdata;
  logic                         mem_we;
  logic [cbas_pkg::MEM_AW-1:0]  mem_waddr;
  logic [cbas_pkg::WORD_W-1:0]  mem_wdata;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q    <= op_i;
      cid_q   <= data_i[1:0];
      cmdin_q <= data_i[3:2];
      addr_q  <= data_i[23:4];
      fw_q    <= data_i[55:24];
      ww_q    <= data_i[87:56];
    end
  end

  // round robin after the last core served
  always_comb begin
    int idx;
    idx       = 0;
    arb_found = 1'b0;
    arb_core  = '0;
    for (int i = 1; i <= cbas_pkg::CORES; i++) begin
      idx = (int'(last_q) + i) % cbas_pkg::CORES;
      if (!arb_found && cnt_q[idx] != '0) begin
        arb_found = 1'b1;
        arb_core  = cbas_pkg::CORE_W'(idx);
      end
    end
  end

  assign bus_free = (cur_cmd_q == cbas_pkg::CMD_NONE && wait_q == '0) ||
                    (cur_cmd_q == cbas_pkg::CMD_FLUSH && offs_q == '0);

  always_comb begin
    priority if (bus_free) begin
      kind = K_ARB;
    end else if (wait_q != '0) begin
      kind = K_WAIT;
    end else if (cur_cmd_q == cbas_pkg::CMD_FLUSH) begin
      kind = K_STEP;
    end else if (offer_v_q) begin
      kind = K_OFFER;
    end else begin
      kind = K_MEMSTART;
    end
  end

  assign rd_core    = (kind == K_ARB) ? arb_core : offer_core_q;
  assign fifo_raddr = {rd_core, head_q[rd_core]};
  assign fl_addr    = (offs_q == '0) ? (cur_addr_q & BASE_MASK)
                                     : cur_addr_q + cbas_pkg::ADDR_W'(1);
  assign mem_raddr  = (op_q == cbas_pkg::OP_MEM_RD) ? addr_q : fl_addr;

  always_ff @(posedge clk_i) begin
    if (ctl_i.read) begin
      fifo_rd_q <= fifo_mem[fifo_raddr];
      mem_rd_q  <= word_mem[mem_raddr];
    end
    if (ctl_i.commit && fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    if (ctl_i.commit && mem_we) begin
      word_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_comb begin
    logic [cbas_pkg::CMD_W-1:0]  e_cmd;
    logic [cbas_pkg::ADDR_W-1:0] e_addr;
    logic [cbas_pkg::CORE_W-1:0] ce;
    e_cmd  = fifo_rd_q[cbas_pkg::ENTRY_W-1:cbas_pkg::ADDR_W];
    e_addr = fifo_rd_q[cbas_pkg::ADDR_W-1:0];
    ce     = cbas_pkg::CORE_W'(cid_q);

    cnt_d        = cnt_q;
    head_d       = head_q;
    last_d       = last_q;
    cur_cmd_d    = cur_cmd_q;
    cur_org_d    = cur_org_q;
    cur_addr_d   = cur_addr_q;
    cur_word_d   = cur_word_q;
    shared_d     = shared_q;
    wait_d       = wait_q;
    offs_d       = offs_q;
    offer_v_d    = offer_v_q;
    offer_core_d = offer_core_q;
    offer_addr_d = offer_addr_q;

    fifo_we    = 1'b0;
    fifo_waddr = {ce, head_q[ce] + cnt_q[ce][cbas_pkg::HEAD_W-1:0]};
    fifo_wdata = {cmdin_q, addr_q};
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = ww_q;

    res_trace_d  = 1'b0;
    res_cmd_d    = '0;
    res_org_d    = '0;
    res_addr_d   = '0;
    res_word_d   = '0;
    res_shared_d = 1'b0;
    res_acc_d    = 1'b0;
    res_rdw_d    = '0;

    case (op_q)
      cbas_pkg::OP_ENQUEUE: begin
        if (32'(cid_q) < cbas_pkg::CORES && cmdin_q != cbas_pkg::CMD_NONE &&
            32'(cnt_q[ce]) < cbas_pkg::QUEUE_DEPTH) begin
          fifo_we   = 1'b1;
          cnt_d[ce] = cnt_q[ce] + cbas_pkg::CNT_W'(1);
          res_acc_d = 1'b1;
        end
      end
      cbas_pkg::OP_TICK: begin
        unique case (kind)
          K_ARB: begin
            cur_cmd_d = cbas_pkg::CMD_NONE;
            if (arb_found) begin
              head_d[arb_core] = head_q[arb_core] + cbas_pkg::HEAD_W'(1);
              cnt_d[arb_core]  = cnt_q[arb_core] - cbas_pkg::CNT_W'(1);
              last_d     = arb_core;
              cur_cmd_d  = e_cmd;
              cur_org_d  = cbas_pkg::ORG_W'(arb_core);
              cur_addr_d = e_addr;
              offs_d     = '0;
              if (e_cmd != cbas_pkg::CMD_FLUSH) begin
                shared_d = 1'b0;
              end else begin
                // core flush puts out its first word at once
                cur_addr_d = e_addr & BASE_MASK;
                cur_word_d = fw_q;
                mem_we     = 1'b1;
                mem_waddr  = e_addr & BASE_MASK;
                mem_wdata  = fw_q;
                offs_d     = cbas_pkg::OFFS_W'(1);
              end
            end
          end
          K_WAIT, K_STEP: begin
            if (kind == K_WAIT) begin
              wait_d = wait_q - cbas_pkg::WAIT_W'(1);
            end
            if (kind == K_STEP || wait_q == cbas_pkg::WAIT_W'(1)) begin
              cur_cmd_d  = cbas_pkg::CMD_FLUSH;
              cur_addr_d = fl_addr;
              if (cur_org_q == cbas_pkg::ORIGIN_MEMORY) begin
                cur_word_d = mem_rd_q;
              end else begin
                cur_word_d = fw_q;
                mem_we     = 1'b1;
                mem_waddr  = fl_addr;
                mem_wdata  = fw_q;
              end
              offs_d = (offs_q == cbas_pkg::OFFS_W'(cbas_pkg::BLOCK_WORDS - 1))
                       ? '0 : offs_q + cbas_pkg::OFFS_W'(1);
            end
          end
          K_OFFER: begin
            // drop a flush of the same block at the head of the offering core's queue
            if (cnt_q[offer_core_q] != '0 && e_cmd == cbas_pkg::CMD_FLUSH &&
                (e_addr & BASE_MASK) == (offer_addr_q & BASE_MASK)) begin
              head_d[offer_core_q] = head_q[offer_core_q] + cbas_pkg::HEAD_W'(1);
              cnt_d[offer_core_q]  = cnt_q[offer_core_q] - cbas_pkg::CNT_W'(1);
            end
            offer_v_d  = 1'b0;
            cur_cmd_d  = cbas_pkg::CMD_FLUSH;
            cur_org_d  = cbas_pkg::ORG_W'(offer_core_q);
            cur_addr_d = offer_addr_q & BASE_MASK;
            cur_word_d = fw_q;
            mem_we     = 1'b1;
            mem_waddr  = offer_addr_q & BASE_MASK;
            mem_wdata  = fw_q;
            offs_d     = cbas_pkg::OFFS_W'(1);
          end
          K_MEMSTART: begin
            wait_d    = cbas_pkg::WAIT_W'(cbas_pkg::MEMORY_WAIT);
            cur_cmd_d = cbas_pkg::CMD_NONE;
            cur_org_d = cbas_pkg::ORIGIN_MEMORY;
            offs_d    = '0;
          end
          default: begin
            cur_cmd_d = cur_cmd_q;
          end
        endcase
        if (cur_cmd_d != cbas_pkg::CMD_NONE) begin
          res_trace_d  = 1'b1;
          res_cmd_d    = cur_cmd_d;
          res_org_d    = cur_org_d;
          res_addr_d   = cur_addr_d;
          res_word_d   = cur_word_d;
          res_shared_d = shared_d;
        end
      end
      cbas_pkg::OP_OFFER: begin
        if (32'(cid_q) < cbas_pkg::CORES) begin
          offer_v_d    = 1'b1;
          offer_core_d = ce;
          offer_addr_d = addr_q;
        end
      end
      cbas_pkg::OP_SHARED: begin
        shared_d = 1'b1;
      end
      cbas_pkg::OP_MEM_WR: begin
        mem_we = 1'b1;
      end
      cbas_pkg::OP_MEM_RD: begin
        res_rdw_d = mem_rd_q;
      end
      default: begin
        shared_d = shared_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < cbas_pkg::CORES; k++) begin
        cnt_q[k]  <= '0;
        head_q[k] <= '0;
      end
      last_q       <= cbas_pkg::CORE_W'(cbas_pkg::CORES - 1);
      cur_cmd_q    <= cbas_pkg::CMD_NONE;
      cur_org_q    <= '0;
      cur_addr_q   <= '0;
      cur_word_q   <= '0;
      shared_q     <= 1'b0;
      wait_q       <= '0;
      offs_q       <= '0;
      offer_v_q    <= 1'b0;
      offer_core_q <= '0;
      offer_addr_q <= '0;
    end else if (ctl_i.commit) begin
      cnt_q        <= cnt_d;
      head_q       <= head_d;
      last_q       <= last_d;
      cur_cmd_q    <= cur_cmd_d;
      cur_org_q    <= cur_org_d;
      cur_addr_q   <= cur_addr_d;
      cur_word_q   <= cur_word_d;
      shared_q     <= shared_d;
      wait_q       <= wait_d;
      offs_q       <= offs_d;
      offer_v_q    <= offer_v_d;
      offer_core_q <= offer_core_d;
      offer_addr_q <= offer_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      res_trace_q  <= res_trace_d;
      res_cmd_q    <= res_cmd_d;
      res_org_q    <= res_org_d;
      res_addr_q   <= res_addr_d;
      res_word_q   <= res_word_d;
      res_shared_q <= res_shared_d;
      res_acc_q    <= res_acc_d;
      res_rdw_q    <= res_rdw_d;
    end
  end

  assign trace_valid_o = res_trace_q;
  assign data_o = {5'b0, res_rdw_q, res_acc_q, res_shared_q, res_word_q,
                   res_addr_q, res_org_q, res_cmd_q};

endmodule
`default_nettype wire

### sim/coherent_bus_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module coherent_bus_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_tvalid_i,
  input  wire logic                                s_tready_i,
  input  wire logic [cbas_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  wire logic [cbas_pkg::OP_W-1:0]           s_tuser_i,
  input  wire logic                                m_tvalid_i,
  input  wire logic                                m_tready_i,
  input  wire logic [cbas_pkg::OUT_TDATA_W-1:0]    m_tdata_i,
  input  wire logic                                m_tuser_i,
  output int                                       fail_count_o,
  output int                                       pending_o
);
  import cbas_pkg::*;

  typedef struct packed {
    logic              trace;
    logic [CMD_W-1:0]  cmd;
    logic [ORG_W-1:0]  origin;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic              shared;
    logic              accepted;
    logic [WORD_W-1:0] rd_word;
  } bus_result_t;

  bus_result_t bus_results_q[$];

  // bus model state
  logic [ENTRY_W-1:0] req_q [CORES][QUEUE_DEPTH];
  int unsigned        req_cnt [CORES];
  int unsigned        req_head [CORES];
  int unsigned        last_core;
  logic [WORD_W-1:0]  mem_words [logic [ADDR_W-1:0]];
  logic [CMD_W-1:0]   cur_cmd;
  logic [ORG_W-1:0]   cur_origin;
  logic [ADDR_W-1:0]  cur_addr;
  logic [WORD_W-1:0]  cur_word;
  logic               shared_q;
  int unsigned        wait_cnt;
  int unsigned        offset_q;
  logic               offer_pending;
  logic [CID_W-1:0]   offer_core;
  logic [ADDR_W-1:0]  offer_addr;

  initial begin
    fail_count_o = 0;
    for (int c = 0; c < CORES; c++) begin
      req_cnt[c]  = 0;
      req_head[c] = 0;
    end
    last_core     = CORES - 1;
    cur_cmd       = CMD_NONE;
    cur_origin    = '0;
    cur_addr      = '0;
    cur_word      = '0;
    shared_q      = 1'b0;
    wait_cnt      = 0;
    offset_q      = 0;
    offer_pending = 1'b0;
    offer_core    = '0;
    offer_addr    = '0;
  end

  assign pending_o = bus_results_q.size();

  function automatic logic [ADDR_W-1:0] blk(input logic [ADDR_W-1:0] a);
    return a - (a % BLOCK_WORDS);
  endfunction

  task automatic flush_beat(input logic [WORD_W-1:0] core_word);
    if (offset_q == 0) cur_addr = blk(cur_addr);
    else cur_addr = cur_addr + 1'b1;
    if (cur_origin == ORIGIN_MEMORY) begin
      cur_word = mem_words.exists(cur_addr) ? mem_words[cur_addr] : '0;
    end else begin
      cur_word = core_word;
      mem_words[cur_addr] = core_word;
    end
    offset_q = (offset_q + 1) % BLOCK_WORDS;
  endtask

  task automatic begin_txn(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] a,
                           input logic [ORG_W-1:0] org, input logic [WORD_W-1:0] cw);
    if (org == ORIGIN_MEMORY) begin
      wait_cnt = MEMORY_WAIT;
      cur_cmd  = CMD_NONE;
    end else begin
      cur_cmd = cmd;
    end
    cur_origin = org;
    cur_addr   = a;
    if (cmd != CMD_FLUSH) shared_q = 1'b0;
    offset_q = 0;
    if (cmd == CMD_FLUSH && org != ORIGIN_MEMORY) flush_beat(cw);
  endtask

  task automatic pop_req(input int unsigned c, output logic [ENTRY_W-1:0] e);
    e = req_q[c][req_head[c]];
    req_head[c] = (req_head[c] + 1) % QUEUE_DEPTH;
    req_cnt[c]--;
  endtask

  task automatic advance_bus(input logic [WORD_W-1:0] cw);
    logic [ENTRY_W-1:0] e;
    int unsigned        c;
    if ((cur_cmd == CMD_NONE && wait_cnt == 0) ||
        (cur_cmd == CMD_FLUSH && offset_q == 0)) begin
      c = last_core;
      cur_cmd = CMD_NONE;
      for (int i = 0; i < CORES; i++) begin
        c = (c + 1) % CORES;
        if (req_cnt[c] != 0) begin
          pop_req(c, e);
          begin_txn(e[ENTRY_W-1:ADDR_W], e[ADDR_W-1:0], ORG_W'(c), cw);
          last_core = c;
          break;
        end
      end
    end else if (wait_cnt > 0) begin
      wait_cnt--;
      if (wait_cnt == 0) begin
        cur_cmd = CMD_FLUSH;
        flush_beat(cw);
      end
    end else if (cur_cmd == CMD_FLUSH) begin
      flush_beat(cw);
    end else if (offer_pending) begin
      c = offer_core;
      if (req_cnt[c] != 0) begin
        e = req_q[c][req_head[c]];
        // a queued flush of the offered block is already covered by the offer
        if (e[ENTRY_W-1:ADDR_W] == CMD_FLUSH && blk(e[ADDR_W-1:0]) == blk(offer_addr))
          pop_req(c, e);
      end
      offer_pending = 1'b0;
      begin_txn(CMD_FLUSH, offer_addr, ORG_W'(c), cw);
    end else begin
      begin_txn(CMD_FLUSH, cur_addr, ORIGIN_MEMORY, '0);
    end
  endtask

  task automatic predict_bus(input logic [OP_W-1:0] op, input logic [IN_TDATA_W-1:0] d);
    bus_result_t        r;
    logic [CID_W-1:0]   core;
    logic [CMD_W-1:0]   cmd;
    logic [ADDR_W-1:0]  a;
    logic [WORD_W-1:0]  fw;
    logic [WORD_W-1:0]  ww;
    int unsigned        slot;
    core = d[1:0];
    cmd  = d[3:2];
    a    = d[23:4];
    fw   = d[55:24];
    ww   = d[87:56];
    r    = '0;
    case (op)
      OP_ENQUEUE: begin
        if (cmd != CMD_NONE && req_cnt[core] < QUEUE_DEPTH) begin
          slot = (req_head[core] + req_cnt[core]) % QUEUE_DEPTH;
          req_q[core][slot] = {cmd, a};
          req_cnt[core]++;
          r.accepted = 1'b1;
        end
      end
      OP_TICK: begin
        advance_bus(fw);
        if (cur_cmd != CMD_NONE) begin
          r.trace  = 1'b1;
          r.cmd    = cur_cmd;
          r.origin = cur_origin;
          r.addr   = cur_addr;
          r.word   = cur_word;
          r.shared = shared_q;
        end
      end
      OP_OFFER: begin
        offer_pending = 1'b1;
        offer_core    = core;
        offer_addr    = a;
      end
      OP_SHARED: shared_q = 1'b1;
      OP_MEM_WR: mem_words[a] = ww;
      OP_MEM_RD: r.rd_word = mem_words.exists(a) ? mem_words[a] : '0;
      default: ;
    endcase
    bus_results_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    bus_result_t x;
    if (rst_ni) begin
      // results first: a result never stems from an input taken at the same edge
      if (m_tvalid_i && m_tready_i) begin
        if (bus_results_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o++;
        end else begin
          x = bus_results_q.pop_front();
          check_field("trace_valid", x.trace, m_tuser_i);
          check_field("bus_command", x.cmd, m_tdata_i[1:0]);
          check_field("bus_origin", x.origin, m_tdata_i[4:2]);
          check_field("bus_address", x.addr, m_tdata_i[24:5]);
          check_field("bus_word", x.word, m_tdata_i[56:25]);
          check_field("bus_shared_line", x.shared, m_tdata_i[57]);
          check_field("accepted", x.accepted, m_tdata_i[58]);
          check_field("read_word", x.rd_word, m_tdata_i[90:59]);
          check_field("zero", '0, m_tdata_i[95:91]);
        end
      end
      if (s_tvalid_i && s_tready_i) predict_bus(s_tuser_i, s_tdata_i);
    end
  end
endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import cbas_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]        s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  int                     fail_count;
  int                     pending;
  int                     burst_left = 0;
  logic [ADDR_W-1:0]      block_pool [12];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  coherent_bus_arbiter_sequencer_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser)
  );

  coherent_bus_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata), .m_tuser_i(m_tuser),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // one transfer on the input side, with bursts and gaps in between
  task automatic send_op(input logic [OP_W-1:0] op, input logic [CID_W-1:0] core,
                         input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] a,
                         input logic [WORD_W-1:0] fw, input logic [WORD_W-1:0] ww);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {ww, fw, a, cmd, core};
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
  endtask

  // word addresses only inside preloaded blocks, so memory flushes read known words
  function automatic logic [ADDR_W-1:0] pool_addr();
    return block_pool[$urandom_range(0, 11)] | ADDR_W'($urandom_range(0, BLOCK_WORDS - 1));
  endfunction

  task automatic ticks(input int n);
    repeat (n) send_op(OP_TICK, '0, '0, '0, $urandom(), $urandom());
  endtask

  initial begin
    int unsigned pick;
    block_pool[0] = '0;
    block_pool[1] = 20'hFFFFC;
    block_pool[2] = 20'h55554;
    block_pool[3] = 20'hAAAA8;
    for (int i = 4; i < 12; i++) block_pool[i] = ADDR_W'($urandom()) & ~ADDR_W'(3);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // preload every pool word
    for (int b = 0; b < 12; b++)
      for (int w = 0; w < BLOCK_WORDS; w++)
        send_op(OP_MEM_WR, '0, '0, block_pool[b] | ADDR_W'(w), '0, $urandom());
    // directed: read then memory flush after the wait
    send_op(OP_ENQUEUE, 2'd0, CMD_READ, 20'hFFFFF, '0, '0);
    send_op(OP_SHARED, '0, '0, '0, '0, '0);
    ticks(22);
    // read exclusive answered by a snoop offer that also drops a duplicate flush
    send_op(OP_ENQUEUE, 2'd1, CMD_RDX, 20'h55555, '0, '0);
    send_op(OP_ENQUEUE, 2'd2, CMD_FLUSH, 20'h55556, '0, '0);
    send_op(OP_OFFER, 2'd2, '0, 20'h55557, '0, '0);
    send_op(OP_OFFER, 2'd2, '0, 20'h55554, '0, '0);
    ticks(8);
    // full queue and a bad command
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_op(OP_ENQUEUE, 2'd3, CMD_FLUSH, pool_addr(), '0, '0);
    send_op(OP_ENQUEUE, 2'd3, CMD_NONE, 20'h0, '0, '0);
    send_op(OP_MEM_RD, '0, '0, 20'hFFFFF, '0, '0);
    send_op(OP_MEM_WR, '0, '0, 20'hFFFFF, '0, 32'hFFFFFFFF);
    send_op(OP_MEM_RD, '0, '0, 20'hFFFFF, '0, '0);
    send_op(3'd6, 2'd3, 2'd3, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_op(3'd7, '0, '0, '0, '0, '0);
    ticks(40);
    // random mix, ticks dominant so the bus keeps moving
    repeat (1900) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)
        send_op(OP_ENQUEUE, CID_W'($urandom()), ($urandom_range(0, 19) == 0) ? CMD_NONE :
                CMD_W'($urandom_range(1, 3)), pool_addr(), $urandom(), $urandom());
      else if (pick < 75)
        send_op(OP_TICK, CID_W'($urandom()), CMD_W'($urandom()), ADDR_W'($urandom()),
                $urandom(), $urandom());
      else if (pick < 83)
        send_op(OP_OFFER, CID_W'($urandom()), CMD_W'($urandom()), pool_addr(),
                $urandom(), $urandom());
      else if (pick < 88)
        send_op(OP_SHARED, CID_W'($urandom()), CMD_W'($urandom()), ADDR_W'($urandom()),
                $urandom(), $urandom());
      else if (pick < 93)
        send_op(OP_MEM_WR, CID_W'($urandom()), CMD_W'($urandom()), ADDR_W'($urandom()),
                $urandom(), $urandom());
      else if (pick < 98)
        send_op(OP_MEM_RD, CID_W'($urandom()), CMD_W'($urandom()), pool_addr(),
                $urandom(), $urandom());
      else
        send_op(OP_W'($urandom_range(6, 7)), CID_W'($urandom()), CMD_W'($urandom()),
                ADDR_W'($urandom()), $urandom(), $urandom());
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: changing stall patterns plus one long hold-off
  initial begin
    int cycle;
    int mode;
    cycle = 0;
    mode  = 0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle % 64 == 0) mode = $urandom_range(0, 3);
      if (cycle >= 3000 && cycle < 3500) m_tready <= 1'b0;
      else if (mode == 0) m_tready <= 1'b1;
      else if (mode == 1) m_tready <= ($urandom_range(0, 1) == 0);
      else if (mode == 2) m_tready <= ($urandom_range(0, 4) == 0);
      else m_tready <= ((cycle % 8) < 5);
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
